// ===== src/abcp_pkg.sv =====
package abcp_pkg;

    localparam int HdrLen = 10;

    typedef logic [7:0] t_byte;
    typedef logic [HdrLen-2:0][7:0] t_hdr;

    localparam t_byte ChU      = 8'h55;
    localparam t_byte ChI      = 8'h49;
    localparam t_byte ChPlus   = 8'h2B;
    localparam t_byte ChEq     = 8'h3D;
    localparam t_byte ChSpace  = 8'h20;
    localparam t_byte ChRead   = 8'h52;
    localparam t_byte ChWrite  = 8'h57;
    localparam t_byte CharBase = 8'h30;

    localparam logic [1:0] PhHeader = 2'd0;
    localparam logic [1:0] PhSkip   = 2'd1;
    localparam logic [1:0] PhHigh   = 2'd2;
    localparam logic [1:0] PhLow    = 2'd3;

    localparam logic [1:0] EvError = 2'd0;
    localparam logic [1:0] EvRead  = 2'd1;
    localparam logic [1:0] EvWrite = 2'd2;
    localparam logic [1:0] EvData  = 2'd3;

    typedef struct packed {
        logic  ok;
        logic  is_write;
        t_byte addr;
        t_byte cnt;
    } t_hdr_res;

    function automatic t_byte pair_value(t_byte hi, t_byte lo);
        return {hi[3:0], 4'b0000} + lo - CharBase;
    endfunction

endpackage

// ===== src/abcp_if.sv =====
interface abcp_rx_if import abcp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface abcp_res_if import abcp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    t_byte      device_address;
    t_byte      byte_count;
    t_byte      data_byte;
    logic       last;

    modport source (output valid, output event_res, output device_address,
                    output byte_count, output data_byte, output last, input ready);
    modport sink   (input valid, input event_res, input device_address,
                    input byte_count, input data_byte, input last, output ready);
endinterface

// ===== src/abcp_hdr_check.sv =====
module abcp_hdr_check import abcp_pkg::*; (
    input  t_hdr     i_held,
    input  t_byte    i_last,
    output t_hdr_res o_res
);

    logic  frame_ok;
    logic  op_rd;
    logic  op_wr;
    t_byte addr;
    t_byte cnt;

    always_comb begin
        frame_ok = (i_held[0] == ChU) && (i_held[1] == ChI) && (i_held[2] == ChPlus)
                && (i_held[4] == ChEq) && (i_held[7] == ChSpace);
        op_rd    = (i_held[3] == ChRead);
        op_wr    = (i_held[3] == ChWrite);
        addr     = pair_value(i_held[5], i_held[6]);
        cnt      = pair_value(i_held[8], i_last);

        o_res.ok       = frame_ok && (op_rd || op_wr) && (addr != 8'd0) && (cnt != 8'd0);
        o_res.is_write = op_wr;
        o_res.addr     = addr;
        o_res.cnt      = cnt;
    end

endmodule

// ===== src/ascii_bridge_command_parser.sv =====
// Serial command parser: takes one received character per word and yields at most one
// result word per character. A header of ten characters "UI+" op '=' AA ' ' CC gives a
// read, write or error result on its tenth character; after a write, one character is
// skipped and each following character pair gives one data byte, the last one marked.
// A character is taken in every cycle and its result appears on the output in the next
// cycle, held in a single result register; the input stalls only while that register
// holds a result that the sink has not yet taken.
module ascii_bridge_command_parser import abcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    abcp_rx_if.sink    i_rx,
    abcp_res_if.source o_res
);

    t_hdr       r_hdr;
    logic [3:0] r_pos, n_pos;
    logic [1:0] r_phase, n_phase;
    t_byte      r_addr, n_addr;
    t_byte      r_cnt, n_cnt;
    t_byte      r_idx, n_idx;
    t_byte      r_pend, n_pend;

    logic       r_ovalid;
    logic [1:0] r_oev;
    t_byte      r_oaddr;
    t_byte      r_ocnt;
    t_byte      r_odata;
    logic       r_olast;

    logic       accept;
    logic       fire;
    logic       hdr_wr;
    logic [1:0] ev;
    t_byte      ev_addr;
    t_byte      ev_cnt;
    t_byte      ev_data;
    logic       ev_last;
    logic       fin;
    t_hdr_res   chk;

    abcp_hdr_check u_hdr_check (
        .i_held (r_hdr),
        .i_last (i_rx.rx_byte),
        .o_res  (chk)
    );

    assign i_rx.ready = !r_ovalid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    assign o_res.valid          = r_ovalid;
    assign o_res.event_res      = r_oev;
    assign o_res.device_address = r_oaddr;
    assign o_res.byte_count     = r_ocnt;
    assign o_res.data_byte      = r_odata;
    assign o_res.last           = r_olast;

    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_pend  = r_pend;
        fire    = 1'b0;
        hdr_wr  = 1'b0;
        ev      = EvError;
        ev_addr = 8'd0;
        ev_cnt  = 8'd0;
        ev_data = 8'd0;
        ev_last = 1'b0;
        fin     = ({1'b0, r_idx} + 9'd1) >= {1'b0, r_cnt};
        unique case (r_phase)
            PhSkip: begin
                n_phase = PhHigh;
            end
            PhHigh: begin
                n_pend  = i_rx.rx_byte;
                n_phase = PhLow;
            end
            PhLow: begin
                fire    = 1'b1;
                ev      = EvData;
                ev_addr = r_addr;
                ev_cnt  = r_cnt;
                ev_data = pair_value(r_pend, i_rx.rx_byte);
                ev_last = fin;
                if (fin) begin
                    n_idx   = 8'd0;
                    n_phase = PhHeader;
                end else begin
                    n_idx   = r_idx + 8'd1;
                    n_phase = PhHigh;
                end
            end
            PhHeader: begin
                if (r_pos == 4'(HdrLen - 1)) begin
                    n_pos = 4'd0;
                    fire  = 1'b1;
                    if (chk.ok) begin
                        ev      = chk.is_write ? EvWrite : EvRead;
                        ev_addr = chk.addr;
                        ev_cnt  = chk.cnt;
                        if (chk.is_write) begin
                            n_addr  = chk.addr;
                            n_cnt   = chk.cnt;
                            n_idx   = 8'd0;
                            n_phase = PhSkip;
                        end
                    end
                end else begin
                    hdr_wr = 1'b1;
                    n_pos  = r_pos + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_phase  <= PhHeader;
            r_addr   <= 8'd0;
            r_cnt    <= 8'd0;
            r_idx    <= 8'd0;
            r_pend   <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_addr  <= n_addr;
                r_cnt   <= n_cnt;
                r_idx   <= n_idx;
                r_pend  <= n_pend;
            end
            if (accept && fire) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hdr_wr) begin
            r_hdr[r_pos] <= i_rx.rx_byte;
        end
        if (accept && fire) begin
            r_oev   <= ev;
            r_oaddr <= ev_addr;
            r_ocnt  <= ev_cnt;
            r_odata <= ev_data;
            r_olast <= ev_last;
        end
    end

endmodule

// ===== sim/tb.sv =====
module tb;
    import abcp_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        t_byte      addr;
        t_byte      count;
        t_byte      data;
        logic       last;
    } t_parse_event;

    class t_parse_tracker;
        t_byte          hdr [HdrLen];
        int             hdr_fill;
        logic [1:0]     ph;
        t_byte          addr_kept;
        t_byte          cnt_kept;
        t_byte          beat_idx;
        t_byte          hi_char;
        t_parse_event   due [$];
        int unsigned    n_bad;

        function new();
            foreach (hdr[i]) hdr[i] = '0;
            hdr_fill  = 0;
            ph        = PhHeader;
            addr_kept = '0;
            cnt_kept  = '0;
            beat_idx  = '0;
            hi_char   = '0;
            n_bad     = 0;
        endfunction

        function t_byte decode_pair(t_byte hi, t_byte lo);
            t_byte up;
            up = hi - CharBase;
            up = up << 4;
            return up + lo - CharBase;
        endfunction

        function void take_char(t_byte c);
            bit         fin;
            bit         ok;
            t_byte      a;
            t_byte      n;
            logic [1:0] k;
            case (ph)
                PhSkip: begin
                    ph = PhHigh;
                end
                PhHigh: begin
                    hi_char = c;
                    ph = PhLow;
                end
                PhLow: begin
                    fin = (int'(beat_idx) + 1) >= int'(cnt_kept);
                    due.push_back(t_parse_event'{EvData, addr_kept, cnt_kept,
                                                 decode_pair(hi_char, c), fin});
                    if (fin) begin
                        beat_idx = '0;
                        ph = PhHeader;
                    end else begin
                        beat_idx = beat_idx + 8'd1;
                        ph = PhHigh;
                    end
                end
                default: begin
                    hdr[hdr_fill] = c;
                    hdr_fill++;
                    if (hdr_fill == HdrLen) begin
                        hdr_fill = 0;
                        ok = hdr[0] == ChU && hdr[1] == ChI && hdr[2] == ChPlus &&
                             hdr[4] == ChEq && hdr[7] == ChSpace;
                        k = EvError;
                        if (ok) begin
                            if (hdr[3] == ChRead) k = EvRead;
                            else if (hdr[3] == ChWrite) k = EvWrite;
                            else ok = 1'b0;
                        end
                        a = decode_pair(hdr[5], hdr[6]);
                        n = decode_pair(hdr[8], hdr[9]);
                        if (a == 8'd0 || n == 8'd0) ok = 1'b0;
                        if (!ok) begin
                            due.push_back(t_parse_event'{EvError, 8'd0, 8'd0, 8'd0, 1'b0});
                            ph = PhHeader;
                        end else begin
                            due.push_back(t_parse_event'{k, a, n, 8'd0, 1'b0});
                            if (k == EvWrite) begin
                                addr_kept = a;
                                cnt_kept  = n;
                                beat_idx  = '0;
                                ph = PhSkip;
                            end else begin
                                ph = PhHeader;
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, t_byte addr, t_byte count,
                                   t_byte data, logic last);
            t_parse_event want;
            if (due.size() == 0) begin
                $error("unexpected result: event_res %0d device_address %0h", kind, addr);
                n_bad++;
                return;
            end
            want = due.pop_front();
            if (kind !== want.kind) begin
                $error("event_res: expected %0d, got %0d", want.kind, kind);
                n_bad++;
            end
            if (addr !== want.addr) begin
                $error("device_address: expected %0h, got %0h", want.addr, addr);
                n_bad++;
            end
            if (count !== want.count) begin
                $error("byte_count: expected %0h, got %0h", want.count, count);
                n_bad++;
            end
            if (data !== want.data) begin
                $error("data_byte: expected %0h, got %0h", want.data, data);
                n_bad++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                n_bad++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    abcp_rx_if  u_rx ();
    abcp_res_if u_res ();

    ascii_bridge_command_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (u_rx),
        .o_res   (u_res)
    );

    t_parse_tracker tracker;
    int             burst_left;
    int             n_sent;
    int unsigned    cyc;
    int             stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_res.valid === 1'b1 && u_res.ready === 1'b1) begin
                tracker.check_result(u_res.event_res, u_res.device_address,
                                     u_res.byte_count, u_res.data_byte, u_res.last);
            end
        end
        cyc++;
        if (cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: u_res.ready <= 1'b1;
            1: u_res.ready <= 1'($urandom_range(0, 1));
            2: u_res.ready <= ($urandom_range(0, 3) == 0);
            default: u_res.ready <= (cyc % 8 != 5) && (cyc % 16 < 12);
        endcase
    end

    function automatic void pick_pair(input t_byte v, output t_byte hi, output t_byte lo);
        t_byte lift;
        if ($urandom_range(0, 3) == 0) hi = t_byte'($urandom_range(0, 255));
        else hi = CharBase + v[7:4];
        lift = hi - CharBase;
        lift = lift << 4;
        lo = v - lift + CharBase;
    endfunction

    task automatic send_char(t_byte c);
        u_rx.valid   <= 1'b1;
        u_rx.rx_byte <= c;
        @(posedge i_clk);
        while (u_rx.ready !== 1'b1) @(posedge i_clk);
        tracker.take_char(c);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(100, 300);
            end else begin
                burst_left = $urandom_range(1, 30);
                u_rx.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(t_byte'(s[i]));
    endtask

    task automatic send_pair(t_byte v);
        t_byte hi;
        t_byte lo;
        pick_pair(v, hi, lo);
        send_char(hi);
        send_char(lo);
    endtask

    task automatic send_header(t_byte op, t_byte a, t_byte n, int flaw);
        t_byte hdr_chars [HdrLen];
        hdr_chars[0] = ChU;
        hdr_chars[1] = ChI;
        hdr_chars[2] = ChPlus;
        hdr_chars[3] = op;
        hdr_chars[4] = ChEq;
        pick_pair(a, hdr_chars[5], hdr_chars[6]);
        hdr_chars[7] = ChSpace;
        pick_pair(n, hdr_chars[8], hdr_chars[9]);
        if (flaw >= 0) hdr_chars[flaw] = hdr_chars[flaw] ^ t_byte'($urandom_range(1, 255));
        foreach (hdr_chars[i]) send_char(hdr_chars[i]);
    endtask

    initial begin
        int    pick;
        t_byte a;
        t_byte n;
        t_byte op;
        tracker      = new();
        burst_left   = 10;
        n_sent       = 0;
        cyc          = 0;
        stall_mode   = 0;
        i_rst_n      = 1'b0;
        u_rx.valid   = 1'b0;
        u_rx.rx_byte = 8'h00;
        u_res.ready  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("UI+R=01 ??");
        send_text("UI+R=?? 01");
        send_text("UI+W=5A 02");
        send_char(8'hFF);
        send_char(8'h00);
        send_char(8'hFF);
        send_text("??");
        send_text("UI+W=12 01");
        send_char(8'h00);
        send_text("00");
        send_text("XI+R=12 34");
        send_text("UX+R=12 34");
        send_text("UI-R=12 34");
        send_text("UI+Q=12 34");
        send_text("UI+r=12 34");
        send_text("UI+R:12 34");
        send_text("UI+R=12_34");
        send_text("UI+R=00 34");
        send_text("UI+W=12 00");
        send_text("UI+R=1  34");
        send_text("UI+R=~~ ~~");
        repeat (HdrLen) send_char(8'h00);
        repeat (HdrLen) send_char(8'hFF);

        while (n_sent < 1000) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                a = t_byte'($urandom_range(1, 255));
                if ($urandom_range(0, 39) == 0) n = t_byte'($urandom_range(1, 255));
                else n = t_byte'($urandom_range(1, 8));
                send_header(ChWrite, a, n, -1);
                send_char(t_byte'($urandom_range(0, 255)));
                repeat (n) send_pair(t_byte'($urandom_range(0, 255)));
            end else if (pick < 65) begin
                send_header(ChRead, t_byte'($urandom_range(0, 255)),
                            t_byte'($urandom_range(0, 255)), -1);
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0: op = ChRead;
                    1: op = ChWrite;
                    default: op = t_byte'($urandom_range(0, 255));
                endcase
                send_header(op, t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(1, 8)),
                            $urandom_range(0, HdrLen - 1));
            end else begin
                repeat ($urandom_range(1, 12)) send_char(t_byte'($urandom_range(0, 255)));
            end
        end
        u_rx.valid <= 1'b0;

        while (tracker.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.n_bad == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
